// ===== src/ledfs_pkg.sv =====
// ---------------------------------------------------------------------------
// ledfs_pkg: shared types and constants of the LED frame sender
// Opcodes, result actions, configuration layout, frame constants and the
// control-frame byte builder.
// ---------------------------------------------------------------------------
package ledfs_pkg;

   // Store and frame geometry
   localparam int LedCount    = 16;
   localparam int RowBytes    = 6;
   localparam int RowDataBits = 8 * RowBytes;
   localparam int FrameRows   = 16;
   localparam int FrameBytes  = 97;
   localparam int StepLatchLo = 98;
   localparam int StepIdle    = 100;
   localparam int StepBits    = 7;
   localparam int RowIdxBits  = 4;
   localparam int ColBits     = 3;
   localparam int LevelBits   = 16;
   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;

   // Control frame content
   localparam logic [6:0] IdxDotEnd   = 7'd42;
   localparam logic [6:0] IdxMaxCur   = 7'd42;
   localparam logic [6:0] IdxBrightR  = 7'd43;
   localparam logic [6:0] IdxBrightGB = 7'd44;
   localparam logic [6:0] IdxFlagsHi  = 7'd45;
   localparam logic [6:0] IdxFlagsLo  = 7'd46;
   localparam logic [6:0] IdxMagicLo  = 7'd47;
   localparam logic [6:0] IdxMagic    = 7'd95;
   localparam logic [7:0] Magic       = 8'h96;
   localparam logic [7:0] DotByte     = 8'hFF;
   localparam logic [7:0] MarkerCtrl  = 8'hFF;
   localparam logic [7:0] MarkerGray  = 8'h00;

   typedef enum logic [1:0] {
      OP_SET_LED    = 2'd0,
      OP_START_GRAY = 2'd1,
      OP_START_CTRL = 2'd2,
      OP_POLL       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ACT_SHIFT    = 2'd0,
      ACT_LATCH_HI = 2'd1,
      ACT_LATCH_LO = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_MARKER   = 2'd0,
      KIND_DATA     = 2'd1,
      KIND_LATCH_HI = 2'd2,
      KIND_LATCH_LO = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_MC_RED    = 3'd0,
      REG_MC_GREEN  = 3'd1,
      REG_MC_BLUE   = 3'd2,
      REG_BR_RED    = 3'd3,
      REG_BR_GREEN  = 3'd4,
      REG_BR_BLUE   = 3'd5,
      REG_FLAGS     = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic [2:0] mc_red;
      logic [2:0] mc_green;
      logic [2:0] mc_blue;
      logic [6:0] br_red;
      logic [6:0] br_green;
      logic [6:0] br_blue;
      logic [4:0] flags;
   } cfg_type;

   // One issued frame step, from the sequencer to the result stage
   typedef struct packed {
      logic                fire;
      kind_type            kind;
      logic                ctrl;
      logic [StepBits-1:0] idx;
      logic [ColBits-1:0]  col;
   } issue_type;

   // Byte idx of the control frame, built from the current registers
   function automatic logic [7:0] control_byte(input logic [6:0] idx, input cfg_type cfg);
      logic [7:0] v;
      if (idx < IdxDotEnd) begin
         v = DotByte;
      end else begin
         case (idx)
            IdxMaxCur:   v = {cfg.mc_blue[1:0], cfg.mc_green, cfg.mc_red};
            IdxBrightR:  v = {cfg.br_red, cfg.mc_blue[2]};
            IdxBrightGB: v = {cfg.br_blue[0], cfg.br_green};
            IdxFlagsHi:  v = {cfg.flags[4], cfg.flags[3], cfg.br_blue[6:1]};
            IdxFlagsLo:  v = {Magic[4:0], cfg.flags[2:0]};
            IdxMagicLo:  v = {5'd0, Magic[7:5]};
            IdxMagic:    v = Magic;
            default:     v = 8'd0;
         endcase
      end
      return v;
   endfunction

endpackage

// ===== src/ledfs_req_if.sv =====
// ---------------------------------------------------------------------------
// ledfs_req_if: request channel of the LED frame sender
// Valid/ready channel carrying one command item.
// ---------------------------------------------------------------------------
interface ledfs_req_if;
   import ledfs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           opcode;
   logic [3:0]           led_index;
   logic [LevelBits-1:0] red_level;
   logic [LevelBits-1:0] green_level;
   logic [LevelBits-1:0] blue_level;
   logic                 transfer_done;

   modport source (
      output valid, opcode, led_index, red_level, green_level, blue_level, transfer_done,
      input  ready
   );
   modport sink (
      input  valid, opcode, led_index, red_level, green_level, blue_level, transfer_done,
      output ready
   );
endinterface

// ===== src/ledfs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ledfs_rsp_if: result channel of the LED frame sender
// Valid/ready channel carrying one frame step item.
// ---------------------------------------------------------------------------
interface ledfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] shift_byte;

   modport source (output valid, action, shift_byte, input ready);
   modport sink (input valid, action, shift_byte, output ready);
endinterface

// ===== src/ledfs_csr.sv =====
// ---------------------------------------------------------------------------
// ledfs_csr: configuration registers
// APB-style register file holding current and brightness codes and flags.
// ---------------------------------------------------------------------------
module ledfs_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ledfs_pkg::CsrAddrBits-1:0]      paddr,
   input  logic [ledfs_pkg::CsrDataBits-1:0]      pwdata,
   output logic [ledfs_pkg::CsrDataBits-1:0]      prdata,
   output logic                                   pready,
   output ledfs_pkg::cfg_type                     cfg
);
   import ledfs_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[4:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MC_RED:   cfg_in.mc_red   = pwdata[2:0];
            REG_MC_GREEN: cfg_in.mc_green = pwdata[2:0];
            REG_MC_BLUE:  cfg_in.mc_blue  = pwdata[2:0];
            REG_BR_RED:   cfg_in.br_red   = pwdata[6:0];
            REG_BR_GREEN: cfg_in.br_green = pwdata[6:0];
            REG_BR_BLUE:  cfg_in.br_blue  = pwdata[6:0];
            REG_FLAGS:    cfg_in.flags    = pwdata[4:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mc_red: 3'd0, mc_green: 3'd0, mc_blue: 3'd0,
                     br_red: 7'd127, br_green: 7'd127, br_blue: 7'd127,
                     flags: 5'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_MC_RED:   prdata = CsrDataBits'(cfg_ff.mc_red);
         REG_MC_GREEN: prdata = CsrDataBits'(cfg_ff.mc_green);
         REG_MC_BLUE:  prdata = CsrDataBits'(cfg_ff.mc_blue);
         REG_BR_RED:   prdata = CsrDataBits'(cfg_ff.br_red);
         REG_BR_GREEN: prdata = CsrDataBits'(cfg_ff.br_green);
         REG_BR_BLUE:  prdata = CsrDataBits'(cfg_ff.br_blue);
         REG_FLAGS:    prdata = CsrDataBits'(cfg_ff.flags);
         default:      prdata = '0;
      endcase
   end
endmodule

// ===== src/ledfs_store.sv =====
// ---------------------------------------------------------------------------
// ledfs_store: grayscale store
// One row of six bytes per LED, written whole, read one row a cycle with a
// registered read. Rows never written read as zero.
// ---------------------------------------------------------------------------
module ledfs_store #(
   parameter int LED_COUNT = ledfs_pkg::LedCount
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [ledfs_pkg::RowIdxBits-1:0]     wr_row,
   input  logic [ledfs_pkg::RowDataBits-1:0]    wr_data,
   input  logic                                 rd_en,
   input  logic [ledfs_pkg::RowIdxBits-1:0]     rd_row,
   output logic [ledfs_pkg::RowDataBits-1:0]    rd_data
);
   import ledfs_pkg::*;

   localparam int AddrBits = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   logic [RowDataBits-1:0] mem [LED_COUNT];
   logic [LED_COUNT-1:0]   valid_ff;
   logic [LED_COUNT-1:0]   valid_in;
   logic [RowDataBits-1:0] rd_data_ff;
   logic                   rd_hit_ff;
   logic                   rd_hit_in;
   logic                   wr_ok;
   logic                   rd_ok;

   assign wr_ok = wr_en && (32'(wr_row) < LED_COUNT);
   assign rd_ok = 32'(rd_row) < LED_COUNT;

   // Mark rows as written
   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_row[AddrBits-1:0]] = 1'b1;
      end
   end

   assign rd_hit_in = rd_ok && valid_ff[rd_row[AddrBits-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_hit_ff <= rd_hit_in;
         end
      end
   end

   // Memory array: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_row[AddrBits-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row[AddrBits-1:0]];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;
endmodule

// ===== src/ledfs_seq.sv =====
// ---------------------------------------------------------------------------
// ledfs_seq: frame sequencer
// Tracks the frame step and the store row and byte that go out next, and
// issues at most one frame step per accepted poll.
// ---------------------------------------------------------------------------
module ledfs_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [1:0]                           opcode,
   input  logic                                 transfer_done,
   output ledfs_pkg::issue_type                 issue,
   output logic [ledfs_pkg::RowIdxBits-1:0]     rd_row
);
   import ledfs_pkg::*;

   logic [StepBits-1:0]   step_ff, step_in;
   logic [RowIdxBits-1:0] row_ff, row_in;
   logic [ColBits-1:0]    col_ff, col_in;
   logic                  ctrl_ff, ctrl_in;
   opcode_type            op;

   assign op     = opcode_type'(opcode);
   assign rd_row = row_ff;

   // Next step and issued item
   always_comb begin
      step_in    = step_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      ctrl_in    = ctrl_ff;
      issue.fire = 1'b0;
      issue.kind = KIND_MARKER;
      issue.ctrl = ctrl_ff;
      issue.idx  = StepBits'(FrameBytes - 1) - step_ff;
      issue.col  = col_ff;
      if (accept) begin
         unique case (op) inside
            OP_SET_LED: ;
            OP_START_GRAY, OP_START_CTRL: begin
               if (step_ff > StepBits'(StepLatchLo)) begin
                  step_in = '0;
                  ctrl_in = (op == OP_START_CTRL);
               end
            end
            OP_POLL: begin
               if (step_ff == '0) begin
                  issue.fire = 1'b1;
                  issue.kind = KIND_MARKER;
                  step_in    = StepBits'(1);
                  row_in     = RowIdxBits'(FrameRows - 1);
                  col_in     = ColBits'(RowBytes - 1);
               end else if (step_ff < StepBits'(FrameBytes)) begin
                  if (transfer_done) begin
                     issue.fire = 1'b1;
                     issue.kind = KIND_DATA;
                     step_in    = step_ff + StepBits'(1);
                     if (col_ff == '0) begin
                        col_in = ColBits'(RowBytes - 1);
                        row_in = row_ff - RowIdxBits'(1);
                     end else begin
                        col_in = col_ff - ColBits'(1);
                     end
                  end
               end else if (step_ff == StepBits'(FrameBytes)) begin
                  issue.fire = 1'b1;
                  issue.kind = KIND_LATCH_HI;
                  step_in    = StepBits'(StepLatchLo);
               end else if (step_ff == StepBits'(StepLatchLo)) begin
                  issue.fire = 1'b1;
                  issue.kind = KIND_LATCH_LO;
                  step_in    = StepBits'(StepLatchLo + 1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepBits'(StepIdle);
         row_ff  <= '0;
         col_ff  <= '0;
         ctrl_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         ctrl_ff <= ctrl_in;
      end
   end
endmodule

// ===== src/rgb_led_driver_frame_sender.sv =====
// ---------------------------------------------------------------------------
// rgb_led_driver_frame_sender: serial frame sender for an RGB LED driver
// Grayscale store, frame sequencer and result stage with a register port.
// ---------------------------------------------------------------------------
// Takes one command item per clock cycle unless stalled. A set-led item writes
// one six-byte row of the grayscale store; a start item arms a grayscale or
// control frame when the sender is idle; each poll item yields the next frame
// step: the marker byte, the 96 data bytes (each only when transfer_done is
// set), then latch-high and latch-low. A step's result item passes through
// stage 1, which holds it during the registered store read, and then the
// output register. The request side stalls only while that output register
// is held by the sink. The store rows start out zero through per-row valid
// bits, so no clearing pass follows reset.
// ---------------------------------------------------------------------------
module rgb_led_driver_frame_sender #(
   parameter int LED_COUNT = ledfs_pkg::LedCount
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ledfs_req_if.sink                            req,
   ledfs_rsp_if.source                          rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ledfs_pkg::CsrAddrBits-1:0]    paddr,
   input  logic [ledfs_pkg::CsrDataBits-1:0]    pwdata,
   output logic [ledfs_pkg::CsrDataBits-1:0]    prdata,
   output logic                                 pready
);
   import ledfs_pkg::*;

   cfg_type                cfg;
   issue_type              issue;
   logic [RowIdxBits-1:0]  rd_row;
   logic [RowDataBits-1:0] row_data;
   logic                   accept;
   logic                   s1_move;

   logic                   s1_valid_ff, s1_valid_in;
   kind_type               s1_kind_ff;
   logic                   s1_ctrl_ff;
   logic [StepBits-1:0]    s1_idx_ff;
   logic [ColBits-1:0]     s1_col_ff;

   logic                   out_valid_ff, out_valid_in;
   action_type             out_action_ff, out_action_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic [7:0]             store_byte;

   ledfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: stage 1 drains into the output register
   assign s1_move   = !out_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || s1_move;
   assign accept    = req.valid && req.ready;

   ledfs_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .opcode        (req.opcode),
      .transfer_done (req.transfer_done),
      .issue         (issue),
      .rd_row        (rd_row)
   );

   ledfs_store #(
      .LED_COUNT (LED_COUNT)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (opcode_type'(req.opcode) == OP_SET_LED)),
      .wr_row  (req.led_index),
      .wr_data ({req.red_level, req.green_level, req.blue_level}),
      .rd_en   (issue.fire && (issue.kind == KIND_DATA)),
      .rd_row  (rd_row),
      .rd_data (row_data)
   );

   // Stage 1: hold the issued step while the store read completes
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue.fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.fire) begin
         s1_kind_ff <= issue.kind;
         s1_ctrl_ff <= issue.ctrl;
         s1_idx_ff  <= issue.idx;
         s1_col_ff  <= issue.col;
      end
   end

   // Pick the byte of the row
   always_comb begin
      case (s1_col_ff)
         3'd0:    store_byte = row_data[7:0];
         3'd1:    store_byte = row_data[15:8];
         3'd2:    store_byte = row_data[23:16];
         3'd3:    store_byte = row_data[31:24];
         3'd4:    store_byte = row_data[39:32];
         3'd5:    store_byte = row_data[47:40];
         default: store_byte = 8'd0;
      endcase
   end

   // Form the result item and load the output register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_action_in = out_action_ff;
      out_byte_in   = out_byte_ff;
      if (s1_valid_ff && s1_move) begin
         out_valid_in = 1'b1;
         unique case (s1_kind_ff)
            KIND_MARKER: begin
               out_action_in = ACT_SHIFT;
               out_byte_in   = s1_ctrl_ff ? MarkerCtrl : MarkerGray;
            end
            KIND_DATA: begin
               out_action_in = ACT_SHIFT;
               out_byte_in   = s1_ctrl_ff ? control_byte(s1_idx_ff, cfg) : store_byte;
            end
            KIND_LATCH_HI: begin
               out_action_in = ACT_LATCH_HI;
               out_byte_in   = 8'd0;
            end
            KIND_LATCH_LO: begin
               out_action_in = ACT_LATCH_LO;
               out_byte_in   = 8'd0;
            end
            default: begin
               out_action_in = ACT_SHIFT;
               out_byte_in   = 8'd0;
            end
         endcase
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_action_ff <= out_action_in;
      out_byte_ff   <= out_byte_in;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.action     = out_action_ff;
   assign rsp.shift_byte = out_byte_ff;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the RGB LED frame sender
// Drives command items with random gaps, mirrors the grayscale store, the
// frame sequencer and the control registers in a local predictor, and checks
// every frame step that comes out against the predicted byte and action.
// ---------------------------------------------------------------------------
module tb;
   import ledfs_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int UnusedRegIdx = 7;
   localparam int PhaseItems   = 208;
   localparam int HoldAfter    = 150;
   localparam int HoldCycles   = 300;

   typedef struct {
      opcode_type           op;
      logic [3:0]           led;
      logic [LevelBits-1:0] red;
      logic [LevelBits-1:0] green;
      logic [LevelBits-1:0] blue;
      logic                 done;
   } led_cmd_type;

   typedef struct {
      action_type act;
      logic [7:0] data;
   } frame_step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [CsrAddrBits-1:0] paddr;
   logic [CsrDataBits-1:0] pwdata;
   logic [CsrDataBits-1:0] prdata;
   logic                   pready;

   ledfs_req_if req_bus ();
   ledfs_rsp_if rsp_bus ();

   rgb_led_driver_frame_sender i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state
   logic [7:0]  gray_shadow [96];
   int unsigned seq_step;
   logic        ctrl_active;
   cfg_type     csr_shadow;
   int          gray_frames;
   int          ctrl_frames;

   // Stimulus and scoreboard
   led_cmd_type    pending_cmds [$];
   frame_step_type expected_steps [$];
   led_cmd_type    cur_cmd;
   frame_step_type drv_step;
   frame_step_type want;
   int unsigned    plan_step;
   int             cmds_taken;
   int             steps_seen;
   int             err_count;
   int             cycle_count;
   int             hold_left;
   logic           hold_done;
   logic           calm;

   // Clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Both sides run without gaps during this window
   assign calm = (cycle_count >= 800) && (cycle_count < 1300);

   // Byte pos of the control frame from the current register copy
   function automatic logic [7:0] ctrl_frame_byte(input int unsigned pos);
      logic [15:0] w;
      if (pos < IdxDotEnd) begin
         w = 16'hFF;
      end else begin
         case (pos)
            IdxMaxCur:   w = (csr_shadow.mc_blue << 6) | (csr_shadow.mc_green << 3) |
                             csr_shadow.mc_red;
            IdxBrightR:  w = (csr_shadow.br_red << 1) | (csr_shadow.mc_blue >> 2);
            IdxBrightGB: w = (csr_shadow.br_blue << 7) | csr_shadow.br_green;
            IdxFlagsHi:  w = (csr_shadow.flags[4] << 7) | (csr_shadow.flags[3] << 6) |
                             (csr_shadow.br_blue >> 1);
            IdxFlagsLo:  w = (Magic << 3) | csr_shadow.flags[2:0];
            IdxMagicLo:  w = Magic >> 5;
            IdxMagic:    w = Magic;
            default:     w = 16'h0;
         endcase
      end
      return w[7:0];
   endfunction

   // Advance the sequencer copy by one command; return 1 when a step comes out
   function automatic bit next_frame_step(input led_cmd_type c, output frame_step_type s);
      int unsigned base;
      int unsigned pos;
      s.act  = ACT_SHIFT;
      s.data = 8'h00;
      case (c.op)
         OP_SET_LED: begin
            if (c.led < LedCount) begin
               base = c.led * RowBytes;
               gray_shadow[base]     = c.blue[7:0];
               gray_shadow[base + 1] = c.blue[15:8];
               gray_shadow[base + 2] = c.green[7:0];
               gray_shadow[base + 3] = c.green[15:8];
               gray_shadow[base + 4] = c.red[7:0];
               gray_shadow[base + 5] = c.red[15:8];
            end
            return 1'b0;
         end
         OP_START_GRAY, OP_START_CTRL: begin
            if (seq_step > StepLatchLo) begin
               seq_step    = 0;
               ctrl_active = (c.op == OP_START_CTRL);
               if (ctrl_active) ctrl_frames++;
               else gray_frames++;
            end
            return 1'b0;
         end
         default: begin
            if (seq_step == 0) begin
               s.data   = ctrl_active ? MarkerCtrl : MarkerGray;
               seq_step = 1;
               return 1'b1;
            end else if (seq_step < FrameBytes) begin
               // data bytes wait for the previous transfer
               if (!c.done) return 1'b0;
               pos      = FrameBytes - 1 - seq_step;
               s.data   = ctrl_active ? ctrl_frame_byte(pos) : gray_shadow[pos];
               seq_step = seq_step + 1;
               return 1'b1;
            end else if (seq_step == FrameBytes) begin
               s.act    = ACT_LATCH_HI;
               seq_step = StepLatchLo;
               return 1'b1;
            end else if (seq_step == StepLatchLo) begin
               s.act    = ACT_LATCH_LO;
               seq_step = StepLatchLo + 1;
               return 1'b1;
            end
            return 1'b0;
         end
      endcase
   endfunction

   function automatic led_cmd_type mk_cmd(input opcode_type op, input logic [3:0] led,
                                          input logic [15:0] r, input logic [15:0] g,
                                          input logic [15:0] b, input logic done);
      led_cmd_type c;
      c.op    = op;
      c.led   = led;
      c.red   = r;
      c.green = g;
      c.blue  = b;
      c.done  = done;
      return c;
   endfunction

   // Queue a command and track where the frame will stand after it
   task automatic queue_cmd(input led_cmd_type c);
      pending_cmds.push_back(c);
      if (c.op == OP_START_GRAY || c.op == OP_START_CTRL) begin
         if (plan_step > StepLatchLo) plan_step = 0;
      end else if (c.op == OP_POLL) begin
         if (plan_step == 0) plan_step = 1;
         else if (plan_step < FrameBytes && c.done) plan_step++;
         else if (plan_step == FrameBytes) plan_step = StepLatchLo;
         else if (plan_step == StepLatchLo) plan_step = StepLatchLo + 1;
      end
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input int idx, input logic [CsrDataBits-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrBits'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_MC_RED:   csr_shadow.mc_red   = value[2:0];
         REG_MC_GREEN: csr_shadow.mc_green = value[2:0];
         REG_MC_BLUE:  csr_shadow.mc_blue  = value[2:0];
         REG_BR_RED:   csr_shadow.br_red   = value[6:0];
         REG_BR_GREEN: csr_shadow.br_green = value[6:0];
         REG_BR_BLUE:  csr_shadow.br_blue  = value[6:0];
         REG_FLAGS:    csr_shadow.flags    = value[4:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [2:0] mcr, input logic [2:0] mcg,
                                 input logic [2:0] mcb, input logic [6:0] brr,
                                 input logic [6:0] brg, input logic [6:0] brb,
                                 input logic [4:0] flags);
      csr_write(REG_MC_RED, CsrDataBits'(mcr));
      csr_write(REG_MC_GREEN, CsrDataBits'(mcg));
      csr_write(REG_MC_BLUE, CsrDataBits'(mcb));
      csr_write(REG_BR_RED, CsrDataBits'(brr));
      csr_write(REG_BR_GREEN, CsrDataBits'(brg));
      csr_write(REG_BR_BLUE, CsrDataBits'(brb));
      csr_write(REG_FLAGS, CsrDataBits'(flags));
   endtask

   // Wait until every item is taken and every step has come out, then settle
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_steps.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Random commands, mostly well-formed frames with data written in between
   task automatic queue_random(input int count);
      led_cmd_type c;
      int unsigned pick;
      repeat (count) begin
         c = mk_cmd(OP_POLL, 4'($urandom_range(0, 15)), 16'($urandom), 16'($urandom),
                    16'($urandom), 1'($urandom));
         pick = $urandom_range(0, 99);
         if (plan_step > StepLatchLo) begin
            if (pick < 25) c.op = OP_START_GRAY;
            else if (pick < 50) c.op = OP_START_CTRL;
            else if (pick < 80) c.op = OP_SET_LED;
         end else begin
            if (pick < 80) c.done = ($urandom_range(0, 99) < 85);
            else if (pick < 94) c.op = OP_SET_LED;
            else c.op = ($urandom_range(0, 1) != 0) ? OP_START_CTRL : OP_START_GRAY;
         end
         queue_cmd(c);
      end
   endtask

   // Driver: present the next command when the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (next_frame_step(cur_cmd, drv_step)) expected_steps.push_back(drv_step);
            cmds_taken <= cmds_taken + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
               cur_cmd = pending_cmds.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.opcode        <= cur_cmd.op;
               req_bus.led_index     <= cur_cmd.led;
               req_bus.red_level     <= cur_cmd.red;
               req_bus.green_level   <= cur_cmd.green;
               req_bus.blue_level    <= cur_cmd.blue;
               req_bus.transfer_done <= cur_cmd.done;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] exp_val);
      if (err_count < 50)
         $display("MISMATCH at %0t: %s: got 0x%02h, expected 0x%02h",
                  $time, what, got, exp_val);
      err_count++;
   endtask

   // Monitor: check each frame step against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            steps_seen <= steps_seen + 1;
            if (expected_steps.size() == 0) begin
               report_mismatch("frame step with nothing pending", rsp_bus.shift_byte, 8'h00);
            end else begin
               want = expected_steps.pop_front();
               if (rsp_bus.action !== want.act)
                  report_mismatch("action", 8'(rsp_bus.action), 8'(want.act));
               if (rsp_bus.shift_byte !== want.data)
                  report_mismatch("shift_byte", rsp_bus.shift_byte, want.data);
            end
         end
         rsp_bus.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 31);
      end
   end

   // Hold off the result side once for a long stretch so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && steps_seen >= HoldAfter) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   // Cycle count and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles, %0d steps still pending",
                  cycle_count, expected_steps.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Sequence: reset, directed frame start, then random phases per register set
   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_SET_LED;
      req_bus.led_index     = '0;
      req_bus.red_level     = '0;
      req_bus.green_level   = '0;
      req_bus.blue_level    = '0;
      req_bus.transfer_done = 1'b0;
      rsp_bus.ready         = 1'b0;
      cycle_count           = 0;
      cmds_taken            = 0;
      steps_seen            = 0;
      err_count             = 0;
      hold_left             = 0;
      hold_done             = 1'b0;
      gray_frames           = 0;
      ctrl_frames           = 0;
      foreach (gray_shadow[i]) gray_shadow[i] = 8'h00;
      seq_step    = StepIdle;
      plan_step   = StepIdle;
      ctrl_active = 1'b0;
      csr_shadow  = '{mc_red: 3'd0, mc_green: 3'd0, mc_blue: 3'd0, br_red: 7'd127,
                      br_green: 7'd127, br_blue: 7'd127, flags: 5'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle poll, level extremes, start while busy, marker without
      // completion, stalled data byte, store rewrite mid-frame
      queue_cmd(mk_cmd(OP_POLL, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      queue_cmd(mk_cmd(OP_SET_LED, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
      queue_cmd(mk_cmd(OP_SET_LED, 4'd15, 16'h0001, 16'h8000, 16'h0000, 1'b1));
      queue_cmd(mk_cmd(OP_SET_LED, 4'd7, 16'hA5A5, 16'h5A5A, 16'h00FF, 1'b0));
      queue_cmd(mk_cmd(OP_START_GRAY, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      queue_cmd(mk_cmd(OP_START_CTRL, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      queue_cmd(mk_cmd(OP_POLL, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      queue_cmd(mk_cmd(OP_POLL, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
      queue_cmd(mk_cmd(OP_POLL, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      queue_cmd(mk_cmd(OP_SET_LED, 4'd15, 16'hC3FF, 16'h1234, 16'hFEDC, 1'b0));
      queue_cmd(mk_cmd(OP_POLL, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      queue_cmd(mk_cmd(OP_START_GRAY, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1));
      wait_quiet();

      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) begin
            write_all_regs(3'd0, 3'd0, 3'd0, 7'd0, 7'd0, 7'd0, 5'd0);
         end else if (phase == 1) begin
            write_all_regs(3'd7, 3'd7, 3'd7, 7'd127, 7'd127, 7'd127, 5'd31);
         end else begin
            write_all_regs(3'($urandom), 3'($urandom), 3'($urandom), 7'($urandom),
                           7'($urandom), 7'($urandom), 5'($urandom));
         end
         // an unmapped register must leave everything untouched
         if (phase == 2) csr_write(UnusedRegIdx, $urandom);
         queue_random(PhaseItems);
         wait_quiet();
      end

      $display("Run covered %0d command items and %0d checked frame steps", cmds_taken,
               steps_seen);
      $display("Frames started: %0d grayscale, %0d control, over 5 register settings",
               gray_frames, ctrl_frames);
      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/ledfs_pkg.sv
src/ledfs_req_if.sv
src/ledfs_rsp_if.sv
src/ledfs_csr.sv
src/ledfs_store.sv
src/ledfs_seq.sv
src/rgb_led_driver_frame_sender.sv
tb/tb.sv
